// File: sv/lapic_tmr_pkg.sv
package lapic_tmr_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int KIND_W      = 2;
	localparam int REG_W       = 32;
	localparam int ADDR_W      = 8;
	localparam int VEC_W       = 8;
	localparam int MODE_W      = 2;
	localparam int DIV_SEL_W   = 4;
	localparam int PRESCALE_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	localparam logic [ADDR_W-1:0] ADDR_ENTRY   = 8'hC8;
	localparam logic [ADDR_W-1:0] ADDR_INITIAL = 8'hE0;
	localparam logic [ADDR_W-1:0] ADDR_CURRENT = 8'hE4;
	localparam logic [ADDR_W-1:0] ADDR_DIVIDE  = 8'hF8;

	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
	localparam int                MASK_BIT      = 16;
	localparam int                MODE_LSB      = 17;
	localparam logic [DIV_SEL_W-1:0] DIVIDE_BITS = 4'hB;

	// bit positions inside the result tdata
	localparam int OUT_FIRE_BIT = 32;
	localparam int OUT_VEC_LSB  = 33;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              mask;
		logic [VEC_W-1:0]  vector;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{mode: '0, mask: 1'b1, vector: '0};

endpackage

// File: sv/local_apic_countdown_timer_core.sv
// Countdown timer with a small register map, fed by a stream of requests:
// a timer tick (tuser 0), a register write (1) or a register read (2). Every
// request yields exactly one result carrying the read data (zero unless a
// read), an interrupt flag and the vector from the timer entry. The block
// takes one request per clock while the result side keeps up: one request
// register, then all register updates together into the result register.
// While a result waits the request register holds and the input stalls; with
// the result side ready, requests flow back to back. Registers:
// 0xC8 timer entry (vector 7:0, mask 16, mode 18:17),
// 0xE0 initial count (a write reloads the count and the prescaler), 0xE4
// current count (read only), 0xF8 divide (bits 3,1,0). The count is
// COUNT_WIDTH bits wide and reads back zero-extended.
module local_apic_countdown_timer_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// reg_addr [7:0], write_data [39:8]
	input  logic [lapic_tmr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// kind [1:0]
	input  logic [lapic_tmr_pkg::KIND_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// read_data [31:0], irq_fire [32], irq_vector [40:33], zero [47:41]
	output logic [lapic_tmr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import lapic_tmr_pkg::*;

	// request register
	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [REG_W-1:0]      data_s1;

	// timer state
	entry_t                  entry_q;
	logic [COUNT_WIDTH-1:0]  init_q;
	logic [COUNT_WIDTH-1:0]  cur_q;
	logic [DIV_SEL_W-1:0]    div_q;
	logic [PRESCALE_W-1:0]   pre_q;

	// result register
	logic                  out_valid_q;
	logic [REG_W-1:0]      out_rd_q;
	logic                  out_fire_q;
	logic [VEC_W-1:0]      out_vec_q;

	logic                  advance;
	logic [2:0]            div_code;
	logic [PRESCALE_W:0]   pre_inc;
	logic [PRESCALE_W:0]   divisor;
	logic                  wrap;
	logic [COUNT_WIDTH-1:0] cur_dec;

	entry_t                  entry_d;
	logic [COUNT_WIDTH-1:0]  init_d;
	logic [COUNT_WIDTH-1:0]  cur_d;
	logic [DIV_SEL_W-1:0]    div_d;
	logic [PRESCALE_W-1:0]   pre_d;
	logic [REG_W-1:0]        rd_c;
	logic                    fire_c;
	logic [VEC_W-1:0]        vec_c;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign div_code = {div_q[3], div_q[1:0]};
	assign pre_inc  = {1'b0, pre_q} + 1'b1;
	assign divisor  = (div_code == 3'd7) ? (PRESCALE_W+1)'(1)
	                                     : (PRESCALE_W+1)'(2) << div_code;
	assign wrap     = pre_inc >= divisor;
	assign cur_dec  = cur_q - 1'b1;

	always_comb begin
		entry_d = entry_q;
		init_d  = init_q;
		cur_d   = cur_q;
		div_d   = div_q;
		pre_d   = pre_q;
		rd_c    = '0;
		fire_c  = 1'b0;
		vec_c   = '0;
		unique case (kind_s1)
			KIND_TICK: begin
				pre_d = wrap ? '0 : pre_inc[PRESCALE_W-1:0];
				if (wrap && cur_q != '0) begin
					cur_d = cur_dec;
					if (cur_dec == '0) begin
						if (entry_q.mode == MODE_PERIODIC)
							cur_d = init_q;
						if (!entry_q.mask) begin
							fire_c = 1'b1;
							vec_c  = entry_q.vector;
						end
					end
				end
			end
			KIND_WRITE: begin
				unique case (addr_s1)
					ADDR_ENTRY: begin
						entry_d.vector = data_s1[VEC_W-1:0];
						entry_d.mask   = data_s1[MASK_BIT];
						entry_d.mode   = data_s1[MODE_LSB +: MODE_W];
					end
					ADDR_INITIAL: begin
						init_d = data_s1[COUNT_WIDTH-1:0];
						cur_d  = data_s1[COUNT_WIDTH-1:0];
						pre_d  = '0;
					end
					ADDR_DIVIDE: div_d = data_s1[DIV_SEL_W-1:0] & DIVIDE_BITS;
					default: ;
				endcase
			end
			KIND_READ: begin
				unique case (addr_s1)
					ADDR_ENTRY: begin
						rd_c[VEC_W-1:0]             = entry_q.vector;
						rd_c[MASK_BIT]              = entry_q.mask;
						rd_c[MODE_LSB +: MODE_W]    = entry_q.mode;
					end
					ADDR_INITIAL: rd_c = REG_W'(init_q);
					ADDR_CURRENT: rd_c = REG_W'(cur_q);
					ADDR_DIVIDE:  rd_c = REG_W'(div_q);
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			entry_q     <= ENTRY_RESET;
			init_q      <= '0;
			cur_q       <= '0;
			div_q       <= '0;
			pre_q       <= '0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				entry_q     <= entry_d;
				init_q      <= init_d;
				cur_q       <= cur_d;
				div_q       <= div_d;
				pre_q       <= pre_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			addr_s1 <= s_axis_tdata[ADDR_W-1:0];
			data_s1 <= s_axis_tdata[ADDR_W +: REG_W];
		end
		if (advance) begin
			out_rd_q   <= rd_c;
			out_fire_q <= fire_c;
			out_vec_q  <= vec_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-OUT_VEC_LSB-VEC_W)'(0), out_vec_q, out_fire_q, out_rd_q};

	// a held request must not be dropped or altered while the result side stalls
	a_hold_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(addr_s1))
		else $error("request register changed while stalled");

	// after an interrupt the count is either stopped or reloaded
	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fire_c |=> (cur_q == '0 || cur_q == init_q))
		else $error("count not stopped or reloaded after interrupt");

	// vector and read data are zero unless the result says otherwise
	a_vec_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_fire_q |-> out_vec_q == '0)
		else $error("vector set without interrupt");

	a_fire_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fire_q |-> out_rd_q == '0)
		else $error("read data on a tick result");

endmodule
